// ===== rtl/hsd_pkg.sv =====
// shared types and constants for the huffman stream decoder
package hsd_pkg;

  localparam int NODE_DEPTH_DEF  = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 13;
  localparam int PAD_W   = 3;
  localparam int PAD_SHIFT = 5;

  localparam logic [SYM_W-1:0] INTERNAL_MARK = 8'h2A;
  localparam logic [SYM_W-1:0] ESCAPE_MARK   = 8'h5C;

  typedef enum logic [1:0] {
    PH_HDR0 = 2'd0,
    PH_HDR1 = 2'd1,
    PH_TREE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_entry_t;

  typedef struct packed {
    logic             side;
    logic [IDX_W-1:0] idx;
  } stack_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);
  localparam int STK_W   = $bits(stack_entry_t);

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             fault;
  } out_item_t;

  function automatic logic [IDX_W-1:0] child_of(node_entry_t e, logic b);
    return b ? e.right : e.left;
  endfunction

endpackage

// ===== rtl/hsd_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
module hsd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [W-1:0]               rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [W-1:0]               wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/hsd_out_stage.sv =====
// output register for decoded items with valid/stall handshake
module hsd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  hsd_pkg::out_item_t push,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        symbol,
  output logic              last_in_run,
  output logic              fault
);
  import hsd_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      symbol      <= push.symbol;
      last_in_run <= push.last;
      fault       <= push.fault;
    end
  end

endmodule

// ===== rtl/huffman_stream_decoder_core.sv =====
// top level of the huffman stream decoder: sequencer around node table and pending stack
//
// Takes one file byte per item: a two-byte header (3 pad bits, 13-bit tree byte count),
// the preorder tree bytes, then data bytes walked msb first. A header byte that raises a
// fault goes through the fault state, which waits while the output side stalls the item.
// A tree byte goes, as needed, through pending-stack read, parent node read, parent write-back,
// new node write and end-of-tree check in turn, as each memory has a single read port. A data
// byte makes one node-table read per data bit, and its walk can wait while the output side
// stalls. Decoded symbols leave through one output register; a bad tree gives one fault
// item and the block waits for a new header. The memories are not cleared after reset and
// need no clearing pass.
module huffman_stream_decoder_core #(
  parameter int NODE_DEPTH  = hsd_pkg::NODE_DEPTH_DEF,
  parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] symbol,
  output logic       last_in_run,
  output logic       fault
);
  import hsd_pkg::*;

  localparam int NCW = $clog2(NODE_DEPTH + 1);
  localparam int NAW = $clog2(NODE_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_STK   = 8'b0000_0010,
    ST_PAR   = 8'b0000_0100,
    ST_NEW   = 8'b0000_1000,
    ST_END   = 8'b0001_0000,
    ST_WALK  = 8'b0010_0000,
    ST_FLUSH = 8'b0100_0000,
    ST_FAULT = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  phase_t              phase, phase_next;
  logic [PAD_W-1:0]    pad_bits, pad_bits_next;
  logic [COUNT_W-1:0]  tree_left, tree_left_next;
  logic                esc, esc_next;
  logic [NCW-1:0]      node_count, node_count_next;
  logic [SPW-1:0]      sp, sp_next;
  logic                hold_valid, hold_valid_next;

  node_entry_t         cur_entry, cur_entry_next;
  node_entry_t         root_entry, root_entry_next;
  logic [SYM_W-1:0]    byte_reg, byte_reg_next;
  logic                eof_reg, eof_reg_next;
  logic                new_leaf, new_leaf_next;
  logic [2:0]          bit_idx, bit_idx_next;
  logic [2:0]          last_idx, last_idx_next;
  logic [SYM_W-1:0]    hold_sym, hold_sym_next;

  logic                node_rd_en, node_wr_en;
  logic [NAW-1:0]      node_rd_addr, node_wr_addr;
  logic [ENTRY_W-1:0]  node_rd_data, node_wr_data;
  logic                stk_rd_en, stk_wr_en;
  logic [SAW-1:0]      stk_rd_addr, stk_wr_addr;
  logic [STK_W-1:0]    stk_rd_data, stk_wr_data;

  out_item_t           push;
  logic                out_free;
  logic                in_accept;
  logic                do_restart;

  hsd_ram #(.W(ENTRY_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk     (clk),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data)
  );

  hsd_ram #(.W(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data)
  );

  hsd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last_in_run (last_in_run),
    .fault       (fault)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    logic [COUNT_W-1:0] tl;
    logic [SPW-1:0]     sp_dec;
    logic [IDX_W-1:0]   idx9;
    logic [IDX_W-1:0]   child;
    logic [2:0]         bit_next;
    node_entry_t        parent;
    node_entry_t        fresh;
    node_entry_t        ncur;
    stack_entry_t       top;

    state_next      = state;
    phase_next      = phase;
    pad_bits_next   = pad_bits;
    tree_left_next  = tree_left;
    esc_next        = esc;
    node_count_next = node_count;
    sp_next         = sp;
    hold_valid_next = hold_valid;
    cur_entry_next  = cur_entry;
    root_entry_next = root_entry;
    byte_reg_next   = byte_reg;
    eof_reg_next    = eof_reg;
    new_leaf_next   = new_leaf;
    bit_idx_next    = bit_idx;
    last_idx_next   = last_idx;
    hold_sym_next   = hold_sym;

    node_rd_en   = 1'b0;
    node_rd_addr = '0;
    node_wr_en   = 1'b0;
    node_wr_addr = '0;
    node_wr_data = '0;
    stk_rd_en    = 1'b0;
    stk_rd_addr  = '0;
    stk_wr_en    = 1'b0;
    stk_wr_addr  = '0;
    stk_wr_data  = '0;
    push         = '0;
    do_restart   = 1'b0;

    tl       = tree_left | COUNT_W'(data_byte);
    sp_dec   = sp - SPW'(1);
    idx9     = IDX_W'(node_count);
    top      = stack_entry_t'(stk_rd_data);
    parent   = node_entry_t'(node_rd_data);
    fresh    = '0;
    ncur     = node_entry_t'(node_rd_data);
    child    = '0;
    bit_next = bit_idx + 3'd1;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          byte_reg_next = data_byte;
          eof_reg_next  = end_of_file;
          unique case (phase)
            PH_HDR0: begin
              pad_bits_next  = PAD_W'(data_byte >> PAD_SHIFT);
              tree_left_next = {data_byte[4:0], 8'h00};
              phase_next     = PH_HDR1;
              if (end_of_file) begin
                state_next = ST_FAULT;
                do_restart = 1'b1;
              end
            end
            PH_HDR1: begin
              tree_left_next  = tl;
              node_count_next = '0;
              sp_next         = '0;
              esc_next        = 1'b0;
              if (tl == '0 || end_of_file) begin
                state_next = ST_FAULT;
                do_restart = 1'b1;
              end else begin
                phase_next = PH_TREE;
              end
            end
            PH_TREE: begin
              if (!esc && data_byte == ESCAPE_MARK) begin
                if (node_count != '0 && sp == '0) begin
                  state_next = ST_FAULT;
                  do_restart = 1'b1;
                end else begin
                  esc_next   = 1'b1;
                  state_next = ST_END;
                end
              end else begin
                new_leaf_next = esc || (data_byte != INTERNAL_MARK);
                esc_next      = 1'b0;
                if (node_count == NCW'(NODE_DEPTH)) begin
                  state_next = ST_FAULT;
                  do_restart = 1'b1;
                end else if (node_count == '0) begin
                  state_next = ST_NEW;
                end else if (sp == '0) begin
                  state_next = ST_FAULT;
                  do_restart = 1'b1;
                end else begin
                  stk_rd_en   = 1'b1;
                  stk_rd_addr = sp_dec[SAW-1:0];
                  state_next  = ST_STK;
                end
              end
            end
            PH_DATA: begin
              last_idx_next   = end_of_file ? (3'd7 - pad_bits) : 3'd7;
              bit_idx_next    = '0;
              hold_valid_next = 1'b0;
              child           = child_of(cur_entry, data_byte[7]);
              node_rd_en      = 1'b1;
              node_rd_addr    = child[NAW-1:0];
              state_next      = ST_WALK;
            end
            default: ;
          endcase
        end
      end

      ST_STK: begin
        node_rd_en   = 1'b1;
        node_rd_addr = top.idx[NAW-1:0];
        state_next   = ST_PAR;
      end

      ST_PAR: begin
        if (top.side) begin
          parent.right = idx9;
          sp_next      = sp_dec;
        end else begin
          parent.left  = idx9;
          stk_wr_en    = 1'b1;
          stk_wr_addr  = sp_dec[SAW-1:0];
          stk_wr_data  = {1'b1, top.idx};
        end
        node_wr_en   = 1'b1;
        node_wr_addr = top.idx[NAW-1:0];
        node_wr_data = parent;
        if (top.idx == '0) begin
          root_entry_next = parent;
        end
        state_next = ST_NEW;
      end

      ST_NEW: begin
        fresh.leaf   = new_leaf;
        fresh.sym    = byte_reg;
        node_wr_en   = 1'b1;
        node_wr_addr = node_count[NAW-1:0];
        node_wr_data = fresh;
        node_count_next = node_count + NCW'(1);
        if (node_count == '0) begin
          root_entry_next = fresh;
        end
        state_next = ST_END;
        if (!new_leaf) begin
          if (sp == SPW'(STACK_DEPTH)) begin
            state_next = ST_FAULT;
            do_restart = 1'b1;
          end else begin
            stk_wr_en   = 1'b1;
            stk_wr_addr = sp[SAW-1:0];
            stk_wr_data = {1'b0, idx9};
            sp_next     = sp + SPW'(1);
          end
        end
      end

      ST_END: begin
        tree_left_next = tree_left - COUNT_W'(1);
        state_next     = ST_IDLE;
        if (tree_left_next == '0) begin
          if (node_count == '0 || sp != '0 || esc || root_entry.leaf) begin
            state_next = ST_FAULT;
            do_restart = 1'b1;
          end else if (eof_reg) begin
            do_restart = 1'b1;
          end else begin
            phase_next     = PH_DATA;
            cur_entry_next = root_entry;
          end
        end else if (eof_reg) begin
          state_next = ST_FAULT;
          do_restart = 1'b1;
        end
      end

      ST_WALK: begin
        if (!(node_rd_data[ENTRY_W-1] && hold_valid && !out_free)) begin
          if (ncur.leaf) begin
            if (hold_valid) begin
              push.valid  = 1'b1;
              push.symbol = hold_sym;
            end
            hold_valid_next = 1'b1;
            hold_sym_next   = ncur.sym;
            ncur            = root_entry;
          end
          cur_entry_next = ncur;
          if (bit_idx == last_idx) begin
            state_next = ST_FLUSH;
          end else begin
            bit_idx_next = bit_next;
            child        = child_of(ncur, byte_reg[3'd7 - bit_next]);
            node_rd_en   = 1'b1;
            node_rd_addr = child[NAW-1:0];
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_valid || out_free) begin
          if (hold_valid) begin
            push.valid  = 1'b1;
            push.symbol = hold_sym;
            push.last   = 1'b1;
          end
          hold_valid_next = 1'b0;
          state_next      = ST_IDLE;
          if (eof_reg) begin
            do_restart = 1'b1;
          end
        end
      end

      ST_FAULT: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.last  = 1'b1;
          push.fault = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (do_restart) begin
      phase_next      = PH_HDR0;
      pad_bits_next   = '0;
      tree_left_next  = '0;
      esc_next        = 1'b0;
      node_count_next = '0;
      sp_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_HDR0;
      pad_bits   <= '0;
      tree_left  <= '0;
      esc        <= 1'b0;
      node_count <= '0;
      sp         <= '0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      pad_bits   <= pad_bits_next;
      tree_left  <= tree_left_next;
      esc        <= esc_next;
      node_count <= node_count_next;
      sp         <= sp_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_entry  <= cur_entry_next;
    root_entry <= root_entry_next;
    byte_reg   <= byte_reg_next;
    eof_reg    <= eof_reg_next;
    new_leaf   <= new_leaf_next;
    bit_idx    <= bit_idx_next;
    last_idx   <= last_idx_next;
    hold_sym   <= hold_sym_next;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> out_free)
    else $error("item pushed while output register is full and stalled");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("pending stack pointer beyond depth");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= NCW'(NODE_DEPTH))
    else $error("node count beyond table depth");

  a_data_walk: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_DATA) |=> (state == ST_WALK && node_count != '0))
    else $error("data byte accepted without a built tree");

  a_fault_item: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.fault) |-> (push.symbol == '0 && push.last))
    else $error("fault item carries a symbol or is not last");

endmodule

// ===== tb/huffman_stream_decoder_core_tb.sv =====
// self-checking testbench for the huffman stream decoder core with a built-in decoder predictor
module huffman_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TOTAL_ITEMS = 260;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       flt;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_file = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] symbol;
  logic       last_in_run;
  logic       fault;

  file_byte_t  pending_bytes[$];
  dec_result_t expected_symbols[$];
  logic [7:0]  tree_code[$];
  int          queued_items = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  // decoder state as predicted
  phase_t       dec_phase;
  logic [2:0]   dec_pad;
  logic [12:0]  dec_left;
  bit           dec_escape;
  node_entry_t  dec_nodes[NODE_DEPTH_DEF];
  int           dec_count;
  stack_entry_t dec_stack[STACK_DEPTH_DEF];
  int           dec_sp;
  logic [8:0]   dec_walk;

  huffman_stream_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last_in_run (last_in_run),
    .fault       (fault)
  );

  always #5 clk = ~clk;

  function automatic void clear_decoder();
    dec_phase = PH_HDR0;
    dec_pad = '0;
    dec_left = '0;
    dec_escape = 1'b0;
    dec_count = 0;
    dec_sp = 0;
    dec_walk = '0;
  endfunction

  function automatic void push_fault();
    dec_result_t r;
    clear_decoder();
    r.sym = 8'h00;
    r.last = 1'b1;
    r.flt = 1'b1;
    expected_symbols.push_back(r);
  endfunction

  function automatic bit attach_node(bit leaf, logic [7:0] s);
    int           idx;
    logic [8:0]   idx9;
    logic [8:0]   pidx;
    stack_entry_t top;
    node_entry_t  ne;
    idx = dec_count;
    if (idx >= NODE_DEPTH_DEF) return 1'b1;
    idx9 = idx[IDX_W-1:0];
    if (idx > 0) begin
      if (dec_sp == 0 || dec_sp > STACK_DEPTH_DEF) return 1'b1;
      top = dec_stack[dec_sp-1];
      pidx = top.idx;
      if (top.side) begin
        dec_nodes[pidx].right = idx9;
        dec_sp = dec_sp - 1;
      end else begin
        dec_nodes[pidx].left = idx9;
        dec_stack[dec_sp-1].side = 1'b1;
      end
    end
    ne.leaf = leaf;
    ne.sym = s;
    ne.left = '0;
    ne.right = '0;
    dec_nodes[idx] = ne;
    dec_count = idx + 1;
    if (!leaf) begin
      if (dec_sp >= STACK_DEPTH_DEF) return 1'b1;
      top.side = 1'b0;
      top.idx = idx9;
      dec_stack[dec_sp] = top;
      dec_sp = dec_sp + 1;
    end
    return 1'b0;
  endfunction

  function automatic bit take_tree_byte(logic [7:0] b);
    if (dec_escape) begin
      dec_escape = 1'b0;
      return attach_node(1'b1, b);
    end
    if (b == INTERNAL_MARK) return attach_node(1'b0, b);
    if (b == ESCAPE_MARK) begin
      if (dec_count > 0 && dec_sp == 0) return 1'b1;
      dec_escape = 1'b1;
      return 1'b0;
    end
    return attach_node(1'b1, b);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eof);
    int          nbits;
    int          n;
    int          j;
    node_entry_t e;
    node_entry_t c;
    logic [8:0]  child;
    logic [7:0]  run_sym[8];
    dec_result_t r;
    case (dec_phase)
      PH_HDR0: begin
        dec_pad = b[7:5];
        dec_left = {b[4:0], 8'h00};
        dec_phase = PH_HDR1;
        if (eof) push_fault();
      end
      PH_HDR1: begin
        dec_left = dec_left | {5'd0, b};
        dec_count = 0;
        dec_sp = 0;
        dec_escape = 1'b0;
        if (dec_left == 0 || eof) push_fault();
        else dec_phase = PH_TREE;
      end
      PH_TREE: begin
        if (take_tree_byte(b)) begin
          push_fault();
          return;
        end
        dec_left = dec_left - 13'd1;
        if (dec_left == 0) begin
          if (dec_count == 0 || dec_sp != 0 || dec_escape || dec_nodes[0].leaf) begin
            push_fault();
            return;
          end
          dec_phase = PH_DATA;
          dec_walk = '0;
        end
        if (eof) begin
          if (dec_phase == PH_DATA) clear_decoder();
          else push_fault();
        end
      end
      default: begin
        nbits = eof ? 8 - int'(dec_pad) : 8;
        n = 0;
        for (j = 0; j < nbits; j++) begin
          e = dec_nodes[dec_walk];
          child = b[7-j] ? e.right : e.left;
          c = dec_nodes[child];
          if (c.leaf) begin
            run_sym[n] = c.sym;
            n++;
            dec_walk = '0;
          end else begin
            dec_walk = child;
          end
        end
        for (j = 0; j < n; j++) begin
          r.sym = run_sym[j];
          r.last = (j == n - 1);
          r.flt = 1'b0;
          expected_symbols.push_back(r);
        end
        if (eof) clear_decoder();
      end
    endcase
  endfunction

  function automatic void add_byte(logic [7:0] b, logic eof);
    file_byte_t f;
    f.data = b;
    f.eof = eof;
    pending_bytes.push_back(f);
    queued_items++;
  endfunction

  function automatic void add_header(int pad, int count);
    logic [12:0] c13;
    logic [2:0]  p3;
    c13 = count[12:0];
    p3 = pad[2:0];
    add_byte({p3, c13[12:8]}, 1'b0);
    add_byte(c13[7:0], 1'b0);
  endfunction

  function automatic void emit_tree(int leaves);
    int         k;
    logic [7:0] sym;
    if (leaves <= 1) begin
      case ($urandom_range(0, 7))
        0: sym = INTERNAL_MARK;
        1: sym = ESCAPE_MARK;
        default: sym = 8'($urandom_range(0, 255));
      endcase
      if (sym == INTERNAL_MARK || sym == ESCAPE_MARK || $urandom_range(0, 9) == 0)
        tree_code.push_back(ESCAPE_MARK);
      tree_code.push_back(sym);
    end else begin
      tree_code.push_back(INTERNAL_MARK);
      k = $urandom_range(1, leaves - 1);
      emit_tree(k);
      emit_tree(leaves - k);
    end
  endfunction

  function automatic void add_tree_file(int leaves, int count_delta, bit with_data);
    int ndata;
    int j;
    tree_code.delete();
    emit_tree(leaves);
    add_header($urandom_range(0, 7), tree_code.size() + count_delta);
    for (j = 0; j < tree_code.size(); j++)
      add_byte(tree_code[j], !with_data && count_delta == 0 && j == tree_code.size() - 1);
    if (with_data) begin
      ndata = $urandom_range(1, 10);
      for (j = 0; j < ndata; j++)
        add_byte(8'($urandom_range(0, 255)), j == ndata - 1);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(data_byte, end_of_file);
      calm = pending_bytes.size() < 40;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          data_byte <= pending_bytes[0].data;
          end_of_file <= pending_bytes[0].eof;
          void'(pending_bytes.pop_front());
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    dec_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_symbols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: symbol %02h last %0b fault %0b",
                     symbol, last_in_run, fault);
        end else begin
          want = expected_symbols.pop_front();
          if (symbol !== want.sym || last_in_run !== want.last || fault !== want.flt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected symbol %02h last %0b fault %0b, got %02h %0b %0b",
                       want.sym, want.last, want.flt, symbol, last_in_run, fault);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        recv_gap = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int leaves;
    int trail;
    int j;
    clear_decoder();

    // end of file inside the header
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b1);
    // empty tree
    add_header(7, 0);
    // single leaf root
    add_header(0, 1);
    add_byte(8'h41, 1'b0);
    // missing child, then escape left open
    add_header(0, 2);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(8'h61, 1'b0);
    add_header(0, 3);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(ESCAPE_MARK, 1'b0);
    // file ends inside the tree, then right after it
    add_header(0, 5);
    add_byte(INTERNAL_MARK, 1'b1);
    add_header(0, 3);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b1);
    // largest count, escaped marks as leaves, then a byte past the complete tree
    add_header(7, 8191);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(ESCAPE_MARK, 1'b0);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(ESCAPE_MARK, 1'b0);
    add_byte(ESCAPE_MARK, 1'b0);
    add_byte(8'h00, 1'b0);
    // eight symbols per byte, last byte keeps one bit
    add_header(7, 3);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h80, 1'b1);
    // deeper tree, no padding
    add_header(0, 5);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(INTERNAL_MARK, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte(8'h5A, 1'b1);

    while (queued_items < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        leaves = ($urandom_range(0, 14) == 0) ? $urandom_range(12, 20) : $urandom_range(2, 8);
        add_tree_file(leaves, 0, $urandom_range(0, 9) != 0);
      end else if (kind < 9) begin
        leaves = $urandom_range(2, 6);
        if ($urandom_range(0, 1) == 0) add_tree_file(leaves, -1, 1'b0);
        else add_tree_file(leaves, $urandom_range(1, 3), 1'b0);
        trail = $urandom_range(1, 3);
        for (j = 0; j < trail; j++) add_byte(8'($urandom_range(0, 255)), j == trail - 1);
      end else begin
        trail = $urandom_range(1, 6);
        for (j = 0; j < trail; j++) add_byte(8'($urandom_range(0, 255)), j == trail - 1);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_symbols.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_symbols.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hsd_pkg.sv
rtl/hsd_ram.sv
rtl/hsd_out_stage.sv
rtl/huffman_stream_decoder_core.sv
tb/huffman_stream_decoder_core_tb.sv
